@@ rtl/iban_mod97_check_digits_core_assert.svh @@
// ----------------------------------------------------------------------------
// iban mod 97 check digits core - assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef IBAN_MOD97_CHECK_DIGITS_CORE_ASSERT_SVH
`define IBAN_MOD97_CHECK_DIGITS_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define IMDC_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IMDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/imdc_pkg.sv @@
// ----------------------------------------------------------------------------
// imdc_pkg
// shared types, constants and mod 97 helpers for the iban check digit core
// ----------------------------------------------------------------------------
package imdc_pkg;

  localparam int MOD97      = 97;
  localparam int CHECK_BASE = 98;
  localparam int HEAD_LEN   = 4;
  localparam int COUNT_MAX  = 5;
  localparam int LETTER_OFS = 55;
  localparam int RADIX      = 10;

  // mod 97 of 100 is 3, so a letter folds as 3r + v
  localparam int LETTER_MUL = 100 % MOD97;

  localparam int STEP_W  = $clog2(HEAD_LEN);
  localparam int COUNT_W = $clog2(COUNT_MAX + 1);

  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5a;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7a;
  localparam logic [7:0] CASE_GAP    = 8'h20;

  // one classified character: digit value or letter value 10..35
  typedef struct packed {
    logic       letter;
    logic [5:0] val;
  } head_t;

  typedef struct packed {
    logic       ok;
    head_t      sym;
  } char_class_t;

  // one finished iban handed from front to back
  typedef struct packed {
    logic              err;
    logic [6:0]        rem;
    head_t [HEAD_LEN-1:0] head;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } check_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cc;
    cc = '0;
    if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
      cc.ok         = 1'b1;
      cc.sym.letter = 1'b0;
      cc.sym.val    = 6'(c - CH_DIGIT_LO);
    end else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
      cc.ok         = 1'b1;
      cc.sym.letter = 1'b1;
      cc.sym.val    = 6'(c - 8'(LETTER_OFS));
    end else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
      cc.ok         = 1'b1;
      cc.sym.letter = 1'b1;
      cc.sym.val    = 6'(c - CASE_GAP - 8'(LETTER_OFS));
    end
    return cc;
  endfunction

  // x below 16 * 97, reduced by conditional subtracts of 8, 4, 2, 1 times 97
  function automatic logic [6:0] mod97_reduce(input logic [9:0] x);
    logic [10:0] t;
    t = {1'b0, x};
    if (t >= 11'(MOD97 * 8)) t = t - 11'(MOD97 * 8);
    if (t >= 11'(MOD97 * 4)) t = t - 11'(MOD97 * 4);
    if (t >= 11'(MOD97 * 2)) t = t - 11'(MOD97 * 2);
    if (t >= 11'(MOD97))     t = t - 11'(MOD97);
    return t[6:0];
  endfunction

  function automatic logic [6:0] fold(input logic [6:0] r, input head_t s);
    logic [9:0] x;
    if (s.letter) x = 10'(r) * 10'(LETTER_MUL) + 10'(s.val);
    else          x = 10'(r) * 10'(RADIX) + 10'(s.val);
    return mod97_reduce(x);
  endfunction

  // 98 - r split into decimal digits, tens by reciprocal 205 / 2048
  function automatic check_t split_check(input logic [6:0] r);
    logic [6:0]  chk;
    logic [14:0] prod;
    check_t      d;
    chk    = 7'(CHECK_BASE) - r;
    prod   = 15'(chk) * 15'd205;
    d.tens = 4'(prod >> 11);
    d.ones = 4'(chk - 7'(d.tens) * 7'(RADIX));
    return d;
  endfunction

endpackage

@@ rtl/imdc_front.sv @@
// ----------------------------------------------------------------------------
// imdc_front
// accepts characters, holds the first four and keeps the running remainder
// ----------------------------------------------------------------------------
module imdc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [7:0]        char_code,
  input  logic              last,
  output logic              job_push,
  output imdc_pkg::job_t    job,
  input  imdc_pkg::qstat_t  qstat
);

  imdc_pkg::head_t [imdc_pkg::HEAD_LEN-1:0] head, head_next;
  logic [imdc_pkg::COUNT_W-1:0]             count, count_next;
  logic [6:0]                               rem, rem_next;
  logic                                     bad, bad_next;
  imdc_pkg::char_class_t                    cc;
  logic                                     accept;
  logic                                     in_head;

  assign char_stall = qstat.full;
  assign accept     = char_valid && !char_stall;
  assign job_push   = accept && last;

  always_comb begin
    cc        = imdc_pkg::classify(char_code);
    in_head   = count < imdc_pkg::COUNT_W'(imdc_pkg::HEAD_LEN);
    head_next = head;
    rem_next  = rem;
    bad_next  = bad | ~cc.ok;
    if (in_head) begin
      head_next[count[imdc_pkg::STEP_W-1:0]] = cc.sym;
    end else if (cc.ok) begin
      rem_next = imdc_pkg::fold(rem, cc.sym);
    end
    if (count < imdc_pkg::COUNT_W'(imdc_pkg::COUNT_MAX)) count_next = count + 1'b1;
    else                                                  count_next = count;
    job.err  = bad_next || (count_next < imdc_pkg::COUNT_W'(imdc_pkg::COUNT_MAX));
    job.rem  = rem_next;
    job.head = head_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rem   <= '0;
      bad   <= 1'b0;
    end else if (accept) begin
      if (last) begin
        count <= '0;
        rem   <= '0;
        bad   <= 1'b0;
      end else begin
        count <= count_next;
        rem   <= rem_next;
        bad   <= bad_next;
      end
    end
  end

  // head slots are always rewritten before they are read
  always_ff @(posedge clk) begin
    if (accept) head <= head_next;
  end

endmodule

@@ rtl/imdc_queue.sv @@
// ----------------------------------------------------------------------------
// imdc_queue
// short register queue of finished requests between front and back
// ----------------------------------------------------------------------------
module imdc_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  imdc_pkg::job_t    din,
  input  logic              pop,
  output imdc_pkg::job_t    dout,
  output imdc_pkg::qstat_t  qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  imdc_pkg::job_t       slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     fill;
  logic                 do_push, do_pop;

  assign qstat.full  = fill == CNT_W'(DEPTH);
  assign qstat.empty = fill == '0;
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign dout        = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

endmodule

@@ rtl/imdc_back.sv @@
// ----------------------------------------------------------------------------
// imdc_back
// folds the held head characters one a cycle unless stalled, registers result
// ----------------------------------------------------------------------------
module imdc_back (
  input  logic              clk,
  input  logic              rst,
  input  imdc_pkg::job_t    job,
  input  imdc_pkg::qstat_t  qstat,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [3:0]        check_tens,
  output logic [3:0]        check_ones,
  output logic [6:0]        remainder,
  output logic              error
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FOLD = 1'b1;
  localparam logic [imdc_pkg::STEP_W-1:0] LAST_STEP =
    imdc_pkg::STEP_W'(imdc_pkg::HEAD_LEN - 1);

  logic                                     state;
  logic [imdc_pkg::STEP_W-1:0]              step;
  logic [6:0]                               work_rem;
  imdc_pkg::head_t [imdc_pkg::HEAD_LEN-1:0] work_head;
  logic [6:0]                               fold_rem;
  imdc_pkg::check_t                         digits;
  logic                                     out_free;
  logic                                     load_err;
  logic                                     load_ok;

  assign out_free = !res_valid || !res_stall;
  assign pop      = (state == ST_IDLE) && !qstat.empty && (!job.err || out_free);
  assign load_err = pop && job.err;
  assign load_ok  = (state == ST_FOLD) && (step == LAST_STEP) && out_free;
  assign fold_rem = imdc_pkg::fold(work_rem, work_head[0]);
  assign digits   = imdc_pkg::split_check(fold_rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (load_err || load_ok) res_valid <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (pop && !job.err) begin
            state <= ST_FOLD;
            step  <= '0;
          end
        end
        ST_FOLD: begin
          if (step != LAST_STEP) step <= step + 1'b1;
          else if (out_free)     state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working remainder and head shift, oldest head character at slot 0
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (pop) begin
        work_rem  <= job.rem;
        work_head <= job.head;
      end
    end else if (step != LAST_STEP) begin
      work_rem  <= fold_rem;
      work_head <= work_head >> $bits(imdc_pkg::head_t);
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      check_tens <= '0;
      check_ones <= '0;
      remainder  <= '0;
      error      <= 1'b1;
    end else if (load_ok) begin
      check_tens <= digits.tens;
      check_ones <= digits.ones;
      remainder  <= fold_rem;
      error      <= 1'b0;
    end
  end

endmodule

@@ rtl/iban_mod97_check_digits_core.sv @@
// ----------------------------------------------------------------------------
// iban_mod97_check_digits_core
// iso 7064 mod 97-10 remainder and check digits over an iban given one
// character a request
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload                               | role
//  --------+------------------------+---------------------------------------+---------------
//  char    | char_valid, char_stall | char_code[7:0], last                  | one character
//  res     | res_valid, res_stall   | check_tens, check_ones, remainder,    | one per iban
//          |                        | error                                 |
//
//  a character is taken every cycle unless the request queue is full
//  a good iban's result follows its pop from the queue and the fold of its four
//  held characters, an error result follows its pop; the back folds one per cycle
//  unless res_stall holds it, keeping pace with any iban of five or more characters
//  rst is synchronous and clears the counters, queue and result valid
//  res_stall holds the result register; the queue keeps taking characters
//  until it fills, then char_stall rises
//
module iban_mod97_check_digits_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [3:0] check_tens,
  output logic [3:0] check_ones,
  output logic [6:0] remainder,
  output logic       error
);

  `include "iban_mod97_check_digits_core_assert.svh"

  // finished requests between the front and the back
  imdc_pkg::job_t   push_job;
  imdc_pkg::job_t   head_job;
  imdc_pkg::qstat_t qstat;
  logic             job_push;
  logic             job_pop;

  // front: classify characters, hold the country code and check positions,
  // fold the account part into the running remainder
  imdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last       (last),
    .job_push   (job_push),
    .job        (push_job),
    .qstat      (qstat)
  );

  // short queue so the front keeps taking characters while the back folds
  imdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (push_job),
    .pop   (job_pop),
    .dout  (head_job),
    .qstat (qstat)
  );

  // back: fold the four held characters, form 98 - remainder, register result
  imdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (head_job),
    .qstat      (qstat),
    .pop        (job_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .check_tens (check_tens),
    .check_ones (check_ones),
    .remainder  (remainder),
    .error      (error)
  );

  // an error result carries zero digits and remainder
  `IMDC_ASSERT_HOLDS(a_err_fields_zero, res_valid && error,
    check_tens == 4'd0 && check_ones == 4'd0 && remainder == 7'd0,
    "error result with non-zero fields")

  // good result: check digits and remainder add up to 98
  `IMDC_ASSERT_HOLDS(a_check_sum, res_valid && !error,
    8'(check_tens) * 8'(imdc_pkg::RADIX) + 8'(check_ones) + 8'(remainder)
      == 8'(imdc_pkg::CHECK_BASE),
    "check digits do not match remainder")

  // good result: remainder reduced below 97
  `IMDC_ASSERT_HOLDS(a_rem_range, res_valid && !error,
    remainder < 7'(imdc_pkg::MOD97),
    "remainder not reduced")

endmodule

@@ test/iban_mod97_check_digits_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iban mod 97 checker
// watches both channels of the check digit core, predicts each iban result
// from the accepted characters and compares it field by field
// ----------------------------------------------------------------------------
module iban_mod97_check_digits_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       last,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [3:0] check_tens,
  input  logic [3:0] check_ones,
  input  logic [6:0] remainder,
  input  logic       error,
  output int         fail_count,
  output int         pending,
  output int         result_count,
  output int         flagged_count
);

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
    logic [6:0] rem;
    logic       err;
  } iban_result_t;

  iban_result_t pending_checks[$];

  // per-iban shadow state
  logic [7:0] held_head[imdc_pkg::HEAD_LEN];
  logic [2:0] chars_seen;
  logic [6:0] tail_rem;
  logic       junk_seen;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= imdc_pkg::CH_DIGIT_LO && c <= imdc_pkg::CH_DIGIT_HI) ||
           (c >= imdc_pkg::CH_UPPER_LO && c <= imdc_pkg::CH_UPPER_HI) ||
           (c >= imdc_pkg::CH_LOWER_LO && c <= imdc_pkg::CH_LOWER_HI);
  endfunction

  // one character into the running mod 97 value, anything else leaves it alone
  function automatic logic [6:0] mod97_fold(input logic [6:0] r, input logic [7:0] c);
    int unsigned acc;
    int unsigned up;
    acc = r;
    up  = c;
    if (c >= imdc_pkg::CH_DIGIT_LO && c <= imdc_pkg::CH_DIGIT_HI)
      return 7'((acc * imdc_pkg::RADIX + (up - imdc_pkg::CH_DIGIT_LO)) % imdc_pkg::MOD97);
    if (c >= imdc_pkg::CH_LOWER_LO && c <= imdc_pkg::CH_LOWER_HI)
      up = up - imdc_pkg::CASE_GAP;
    if (up >= imdc_pkg::CH_UPPER_LO && up <= imdc_pkg::CH_UPPER_HI)
      return 7'((acc * 100 + (up - imdc_pkg::LETTER_OFS)) % imdc_pkg::MOD97);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    iban_result_t want;
    logic [6:0]   r;
    int unsigned  chk;
    int           n;
    if (rst) begin
      pending_checks.delete();
      foreach (held_head[i]) held_head[i] = '0;
      chars_seen    = '0;
      tail_rem      = '0;
      junk_seen     = 1'b0;
      fail_count    <= 0;
      result_count  <= 0;
      flagged_count <= 0;
      pending       <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_checks.size() == 0) begin
          $error("iban result with none outstanding: tens %0d ones %0d rem %0d error %0b",
                 check_tens, check_ones, remainder, error);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_checks.pop_front();
          result_count <= result_count + 1;
          if (want.err) flagged_count <= flagged_count + 1;
          if (check_tens !== want.tens || check_ones !== want.ones ||
              remainder !== want.rem || error !== want.err)
            fail_count <= fail_count + 1;
          if (check_tens !== want.tens)
            $error("check_tens: expected %0d, got %0d", want.tens, check_tens);
          if (check_ones !== want.ones)
            $error("check_ones: expected %0d, got %0d", want.ones, check_ones);
          if (remainder !== want.rem)
            $error("remainder: expected %0d, got %0d", want.rem, remainder);
          if (error !== want.err)
            $error("error: expected %0b, got %0b", want.err, error);
        end
      end

      if (char_valid && !char_stall) begin
        if (chars_seen < imdc_pkg::HEAD_LEN) held_head[chars_seen[1:0]] = char_code;
        else                                 tail_rem = mod97_fold(tail_rem, char_code);
        if (!is_alnum(char_code)) junk_seen = 1'b1;
        if (chars_seen < imdc_pkg::COUNT_MAX) chars_seen = chars_seen + 3'd1;

        if (last) begin
          // country code and check positions go in after the account part
          n = (chars_seen < imdc_pkg::HEAD_LEN) ? int'(chars_seen) : imdc_pkg::HEAD_LEN;
          r = tail_rem;
          for (int i = 0; i < n; i++) r = mod97_fold(r, held_head[i]);
          if (junk_seen || chars_seen < imdc_pkg::COUNT_MAX) begin
            want = '{tens: '0, ones: '0, rem: '0, err: 1'b1};
          end else begin
            chk  = imdc_pkg::CHECK_BASE - int'(r);
            want = '{tens: 4'(chk / imdc_pkg::RADIX), ones: 4'(chk % imdc_pkg::RADIX),
                     rem: r, err: 1'b0};
          end
          pending_checks.push_back(want);
          foreach (held_head[i]) held_head[i] = '0;
          chars_seen = '0;
          tail_rem   = '0;
          junk_seen  = 1'b0;
        end
      end
      pending <= pending_checks.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iban check digit core testbench
// feeds ibans one character a request, directed cases first and then random
// well-formed ibans mixed with short and corrupted ones, under three idle
// mixes; the checker beside the core predicts and compares every result
// ----------------------------------------------------------------------------
module tb;

  // character count for the random part, spread over three idle mixes
  localparam int RANDOM_CHARS = 1150;
  localparam int PHASES       = 3;

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  logic [7:0] char_code;
  logic       last;
  logic       res_valid;
  logic       res_stall;
  logic [3:0] check_tens;
  logic [3:0] check_ones;
  logic [6:0] remainder;
  logic       error;

  int fail_count;
  int pending;
  int result_count;
  int flagged_count;

  int chars_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // sender and receiver idle percentages for each phase
  int send_mix[PHASES] = '{34, 75, 0};
  int recv_mix[PHASES] = '{75, 34, 0};

  iban_mod97_check_digits_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last       (last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .check_tens (check_tens),
    .check_ones (check_ones),
    .remainder  (remainder),
    .error      (error)
  );

  iban_mod97_check_digits_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .last          (last),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .check_tens    (check_tens),
    .check_ones    (check_ones),
    .remainder     (remainder),
    .error         (error),
    .fail_count    (fail_count),
    .pending       (pending),
    .result_count  (result_count),
    .flagged_count (flagged_count)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("iban_mod97_check_digits_core: mismatch");
    $finish;
  end

  // one character request; entered and left at a falling edge, valid only
  // assigned once per edge so back-to-back requests keep valid high
  task automatic send_char(input logic [7:0] code, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= code;
    last       <= fin;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    // either case
    if ($urandom_range(1)) return 8'h61 + 8'($urandom_range(25));
    return 8'h41 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // anything that is neither digit nor letter, over the whole byte range
  function automatic logic [7:0] rand_junk();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a));
    return c;
  endfunction

  // mostly well-formed ibans, some short, some with one bad character
  task automatic send_random_iban();
    int         len;
    int         junk_at;
    int         kind;
    logic       zero_check;
    logic [7:0] c;
    kind       = $urandom_range(99);
    zero_check = ($urandom_range(3) == 0);
    junk_at    = -1;
    if (kind < 8)       len = $urandom_range(1, 4);
    else if (kind < 20) len = $urandom_range(15, 34);
    else                len = $urandom_range(5, 12);
    if ($urandom_range(99) < 12) junk_at = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if (i < 2)      c = rand_letter();
      else if (i < 4) c = zero_check ? 8'h30 : rand_digit();
      else            c = $urandom_range(1) ? rand_digit() : rand_letter();
      if (i == junk_at) c = rand_junk();
      send_char(c, i == len - 1);
    end
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain();
    char_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    int target;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_code  = '0;
    last       = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: short ibans of two and one characters
    send_text("Z9");
    send_text("0");
    // exactly five characters, lower case letters at both ends of the alphabet
    send_text("az095");
    // null byte among the held characters
    send_char(8'h00, 1'b0);
    send_text("ABCD");
    // all-ones byte as the final character
    send_text("DE00");
    send_char(8'hff, 1'b1);
    // clean iban straight after the error cases, state must be fresh
    send_text("GB00Z1");
    drain();

    // random part, one idle mix per phase, draining between phases
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = send_mix[ph];
      recv_idle_pct = recv_mix[ph];
      target        = chars_sent + RANDOM_CHARS / PHASES;
      while (chars_sent < target) send_random_iban();
      drain();
    end

    // let anything late still show up as an unexpected result
    repeat (20) @(posedge clk);

    $display("%0d characters sent, %0d iban results compared, %0d of them error results",
             chars_sent, result_count, flagged_count);
    $display("idle mixes: sender/receiver 34/75, then 75/34, then none");
    if (fail_count == 0 && pending == 0) begin
      $display("iban_mod97_check_digits_core: match");
    end else begin
      $display("iban_mod97_check_digits_core: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/imdc_pkg.sv
rtl/imdc_front.sv
rtl/imdc_queue.sv
rtl/imdc_back.sv
rtl/iban_mod97_check_digits_core.sv
test/iban_mod97_check_digits_checker.sv
test/tb.sv
